### rtl/stdsg_pkg.sv
// shared types and constants of the square tone decay sample generator
package stdsg_pkg;

  localparam int unsigned RateDefault = 11025;
  localparam int unsigned CapDefault  = 16384;
  localparam int unsigned MidLevel    = 128;
  localparam int unsigned AmpStart    = 64;
  localparam int unsigned AmpDrop     = 40;

  // floor(n / 1000) == (n * RecipMs) >> RecipShift for any 32-bit n
  localparam logic [28:0] RecipMs    = 29'd274877907;
  localparam int unsigned RecipShift = 38;
  localparam int unsigned NomW       = 23;  // width of rate * ms / 1000
  localparam int unsigned ScaledW    = 22;  // width of index * 40

  typedef struct packed {
    logic [15:0] step_freq;
    logic [15:0] step_ms;
    logic [15:0] sample_index;
    logic [15:0] samples_before;
  } stdsg_req_t;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       sample_valid;
    logic       last_of_step;
  } stdsg_res_t;

  typedef enum logic [0:0] {
    RegSampleRate = 1'b0,
    RegBufferCap  = 1'b1
  } stdsg_reg_e;

  // sideband carried through the period divider
  typedef struct packed {
    logic [15:0]        idx;
    logic [15:0]        total;
    logic [ScaledW-1:0] idx40;
    logic               ok;
    logic               last;
    logic               fnz;
  } stdsg_side1_t;

  // sideband carried through the phase divider
  typedef struct packed {
    stdsg_side1_t s;
    logic [15:0]  half;
  } stdsg_side2_t;

  // sideband carried through the amplitude divider
  typedef struct packed {
    logic ok;
    logic last;
    logic fnz;
    logic hi;
  } stdsg_side3_t;

endpackage

### rtl/stdsg_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module stdsg_div import stdsg_pkg::*; #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 16,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] pay_o
);

  logic [NW:1]   vld_q;
  logic [NW-1:0] nq_q  [1:NW];
  logic [DW-1:0] rem_q [1:NW];
  logic [DW-1:0] den_q [1:NW];
  logic [PW-1:0] pay_q [1:NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   trial;
    logic          take;

    if (g == 0) begin : g_first
      assign v_in   = valid_i;
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = vld_q[g];
      assign nq_in  = nq_q[g];
      assign rem_in = rem_q[g];
      assign den_in = den_q[g];
      assign pay_in = pay_q[g];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      nq_q[g+1]  <= {nq_in[NW-2:0], take};
      rem_q[g+1] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      den_q[g+1] <= den_in;
      pay_q[g+1] <= pay_in;
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = nq_q[NW];
  assign rem_o   = rem_q[NW];
  assign pay_o   = pay_q[NW];

endmodule

### rtl/square_tone_decay_sample_gen.sv
// top level of the square tone decay sample generator
//
// Usage: drive a request on req_i and pulse start; busy is always low, so a
// request is taken at every edge where start is high, one per cycle if needed.
// Each request yields exactly one result on res_o, marked by a one-cycle done_o
// strobe. Results leave in request order. Between a request and its result lie
// the three one-bit-per-stage divider pipelines in a chain (rate / frequency,
// index mod period, scaled index / length) plus the length and output stages;
// one request per cycle is sustained.
// The rate and buffer size registers sit on the APB port at offsets 0x0 and
// 0x4; write them only while no request is in flight. pready is always high.
// Reset clears all valid bits and loads 11025 Hz and a 16384-sample buffer.
// The receiver cannot stall: a result is on res_o for its done_o cycle only.
module square_tone_decay_sample_gen import stdsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  stdsg_req_t  req_i,
  output logic        done_o,
  output stdsg_res_t  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [15:0] rate_q, cap_q;
  logic        cfg_wr;
  stdsg_reg_e  cfg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = stdsg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 16'(RateDefault);
      cap_q  <= 16'(CapDefault);
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegSampleRate: rate_q <= pwdata[15:0];
        RegBufferCap:  cap_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegSampleRate: prdata = {16'd0, rate_q};
      RegBufferCap:  prdata = {16'd0, cap_q};
      default:       prdata = '0;
    endcase
  end

  // stage 1: capture request and configuration
  logic       v1_q;
  stdsg_req_t r1_q;
  logic [15:0] rate1_q, cap1_q;

  // stage 2: rate * ms, room left in buffer
  logic        v2_q;
  logic [31:0] prod2_q;
  logic [15:0] room2_q, idx2_q, freq2_q, rate2_q;
  logic        full2_q;

  // stage 3: nominal length by reciprocal multiply
  logic [60:0]     mag;
  logic            v3_q;
  logic [NomW-1:0] nom3_q;
  logic [15:0]     room3_q, idx3_q, freq3_q, rate3_q;
  logic            full3_q;

  // stage 4: truncated length, flags
  logic [15:0]  total;
  logic         v4_q;
  logic [15:0]  rate4_q, freq4_q;
  stdsg_side1_t s4_q;

  assign mag = 61'(prod2_q) * 61'(RecipMs);

  always_comb begin
    if (full3_q) begin
      total = '0;
    end else if (nom3_q > NomW'(room3_q)) begin
      total = room3_q;
    end else begin
      total = nom3_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q    <= req_i;
    rate1_q <= rate_q;
    cap1_q  <= cap_q;

    prod2_q <= 32'(rate1_q) * 32'(r1_q.step_ms);
    full2_q <= r1_q.samples_before >= cap1_q;
    room2_q <= cap1_q - r1_q.samples_before;
    idx2_q  <= r1_q.sample_index;
    freq2_q <= r1_q.step_freq;
    rate2_q <= rate1_q;

    nom3_q  <= mag[RecipShift +: NomW];
    full3_q <= full2_q;
    room3_q <= room2_q;
    idx3_q  <= idx2_q;
    freq3_q <= freq2_q;
    rate3_q <= rate2_q;

    s4_q.idx   <= idx3_q;
    s4_q.total <= total;
    s4_q.idx40 <= ScaledW'(idx3_q) * ScaledW'(AmpDrop);
    s4_q.ok    <= idx3_q < total;
    s4_q.last  <= idx3_q == (total - 16'd1);
    s4_q.fnz   <= freq3_q != 16'd0;
    rate4_q    <= rate3_q;
    freq4_q    <= freq3_q;
  end

  // period = rate / freq
  logic         vp;
  logic [15:0]  per_quo, per_rem;
  stdsg_side1_t sp;

  stdsg_div #(.NW(16), .DW(16), .PW($bits(stdsg_side1_t))) u_div_per (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (rate4_q),
    .den_i   (freq4_q),
    .pay_i   (s4_q),
    .valid_o (vp),
    .quo_o   (per_quo),
    .rem_o   (per_rem),
    .pay_o   (sp)
  );

  // stage 5: clamp period to at least 2
  logic         v5_q;
  logic [15:0]  per5_q;
  stdsg_side2_t s5_q;
  logic [15:0]  per;

  assign per = (per_quo < 16'd2) ? 16'd2 : per_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= vp;
    end
  end

  always_ff @(posedge clk_i) begin
    per5_q    <= per;
    s5_q.s    <= sp;
    s5_q.half <= per >> 1;
  end

  // phase = idx mod period
  logic         vm;
  logic [15:0]  ph_quo, ph_rem;
  stdsg_side2_t sm;
  stdsg_side3_t s6;

  stdsg_div #(.NW(16), .DW(16), .PW($bits(stdsg_side2_t))) u_div_ph (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (s5_q.s.idx),
    .den_i   (per5_q),
    .pay_i   (s5_q),
    .valid_o (vm),
    .quo_o   (ph_quo),
    .rem_o   (ph_rem),
    .pay_o   (sm)
  );

  assign s6.ok   = sm.s.ok;
  assign s6.last = sm.s.last;
  assign s6.fnz  = sm.s.fnz;
  assign s6.hi   = ph_rem < sm.half;

  // decay step = idx * 40 / length
  logic               va;
  logic [ScaledW-1:0] amp_quo;
  logic [15:0]        amp_rem;
  stdsg_side3_t       sa;

  stdsg_div #(.NW(ScaledW), .DW(16), .PW($bits(stdsg_side3_t))) u_div_amp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vm),
    .num_i   (sm.s.idx40),
    .den_i   (sm.s.total),
    .pay_i   (s6),
    .valid_o (va),
    .quo_o   (amp_quo),
    .rem_o   (amp_rem),
    .pay_o   (sa)
  );

  // output stage: quotient stays below 40 whenever the sample is valid
  logic [7:0] amp;
  logic [7:0] level;
  logic       done_q;
  stdsg_res_t res_q;

  assign amp = 8'(AmpStart) - amp_quo[7:0];

  always_comb begin
    if (sa.ok && sa.fnz) begin
      level = sa.hi ? (8'(MidLevel) + amp) : (8'(MidLevel) - amp);
    end else begin
      level = 8'(MidLevel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= va;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.sample_value <= level;
    res_q.sample_valid <= sa.ok;
    res_q.last_of_step <= sa.ok && sa.last;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // divider outputs and product bits that are not needed
  logic unused_rem;
  assign unused_rem = ^{per_rem, ph_quo, amp_rem, amp_quo[ScaledW-1:8],
                        mag[RecipShift-1:0], sm.s.idx};

endmodule
